// ----- rtl/nvct_pkg.sv -----
// types, codes and helper functions shared by the command tokenizer
`timescale 1ns / 1ps
package nvct_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam int REQ_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int ACTION_W = 4;
	localparam int POS_W    = 8;

	localparam logic [REQ_W-1:0] REQ_CHAR     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RESTART  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_OVERFLOW = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
	localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_BACKTICK  = 8'h60;
	localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;

	// index wraps at the buffer depth, and at 256 by the counter width
	localparam logic [POS_W:0] WRAP_AT =
		(BUFFER_DEPTH >= 256) ? 9'd256 : 9'(BUFFER_DEPTH);

	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_RESTART,
		KIND_OVERFLOW,
		KIND_IGNORE
	} req_kind_t;

	typedef enum logic [1:0] {
		CLS_SEPARATOR,
		CLS_END,
		CLS_WORD,
		CLS_INVALID
	} char_class_t;

	typedef struct packed {
		req_kind_t   kind;
		char_class_t cls;
	} token_t;

	typedef enum logic [2:0] {
		ST_SPACE,
		ST_NAME,
		ST_NAME_GAP,
		ST_VALUE,
		ST_VALUE_GAP,
		ST_COMPLETE
	} parse_state_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE,
		ACT_NAME_START,
		ACT_NAME_END,
		ACT_VALUE_START,
		ACT_VALUE_END,
		ACT_READ,
		ACT_WRITE,
		ACT_INVALID,
		ACT_OVERFLOW,
		ACT_RESTARTED
	} action_t;

	function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
		char_class_t cls;
		priority if (c == CH_BACKSPACE || c == CH_CR || c == CH_SPACE) begin
			cls = CLS_SEPARATOR;
		end else if (c == CH_LF) begin
			cls = CLS_END;
		end else if (c > CH_COMMA && c < CH_COLON) begin
			cls = CLS_WORD;
		end else if (c > CH_BACKTICK && c < CH_LBRACE) begin
			cls = CLS_WORD;
		end else begin
			cls = CLS_INVALID;
		end
		return cls;
	endfunction

	function automatic logic [POS_W-1:0] next_index(input logic [POS_W-1:0] idx);
		logic [POS_W:0] n;
		n = {1'b0, idx} + 9'd1;
		if (n >= WRAP_AT) begin
			n = '0;
		end
		return n[POS_W-1:0];
	endfunction

endpackage

// ----- rtl/nvct_req_if.sv -----
// request channel: request type and received byte
`timescale 1ns / 1ps
interface nvct_req_if;
	logic                          valid;
	logic                          ready;
	logic [nvct_pkg::REQ_W-1:0]    req_type;
	logic [nvct_pkg::CHAR_W-1:0]   char_code;

	modport source(output valid, req_type, char_code, input ready);
	modport sink(input valid, req_type, char_code, output ready);
endinterface

// ----- rtl/nvct_res_if.sv -----
// result channel: action, position and complete flag
`timescale 1ns / 1ps
interface nvct_res_if;
	logic                            valid;
	logic                            ready;
	logic [nvct_pkg::ACTION_W-1:0]   action;
	logic [nvct_pkg::POS_W-1:0]      position;
	logic                            complete;

	modport source(output valid, action, position, complete, input ready);
	modport sink(input valid, action, position, complete, output ready);
endinterface

// ----- rtl/name_value_command_tokenizer.sv -----
// name value command tokenizer: one result per request, one request per cycle while the token queue has room
// a request is held in the token queue, then loaded into the result register; a result stall holds it in the queue
// throughput: one item per cycle while res.ready keeps the result side moving, set by the parser update in the back end
// a four-entry token queue lets request and result sides stall independently
// reset: parser in the space state, position counter zero, queue and result empty
`timescale 1ns / 1ps
module name_value_command_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	nvct_req_if.sink    req,
	nvct_res_if.source  res
);
	import nvct_pkg::*;

	logic   q_ready;
	logic   push;
	token_t push_tok;
	logic   pop;
	logic   head_valid;
	token_t head_tok;

	nvct_front u_front (
		.req      (req),
		.q_ready  (q_ready),
		.push     (push),
		.push_tok (push_tok)
	);

	nvct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (push_tok),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	nvct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (pop),
		.res        (res)
	);
endmodule

// ----- rtl/nvct_front.sv -----
// front end: takes requests and classifies them into tokens
`timescale 1ns / 1ps
module nvct_front (
	nvct_req_if.sink          req,
	input  logic              q_ready,
	output logic              push,
	output nvct_pkg::token_t  push_tok
);
	import nvct_pkg::*;

	assign req.ready = q_ready;
	assign push      = req.valid && q_ready;

	always_comb begin
		push_tok.cls = classify(req.char_code);
		unique case (req.req_type)
			REQ_CHAR:     push_tok.kind = KIND_CHAR;
			REQ_RESTART:  push_tok.kind = KIND_RESTART;
			REQ_OVERFLOW: push_tok.kind = KIND_OVERFLOW;
			default:      push_tok.kind = KIND_IGNORE;
		endcase
	end
endmodule

// ----- rtl/nvct_queue.sv -----
// short token queue between front end and back end
`timescale 1ns / 1ps
module nvct_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nvct_pkg::token_t  push_tok,
	output logic              q_ready,
	input  logic              pop,
	output logic              head_valid,
	output nvct_pkg::token_t  head_tok
);
	import nvct_pkg::*;

	token_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign q_ready    = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- rtl/nvct_back.sv -----
// back end: parser state machine, position counter and result register
`timescale 1ns / 1ps
module nvct_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  nvct_pkg::token_t  head_tok,
	output logic              pop,
	nvct_res_if.source        res
);
	import nvct_pkg::*;

	parse_state_t      state_q;
	parse_state_t      state_d;
	logic [POS_W-1:0]  index_q;
	logic [POS_W-1:0]  index_d;
	action_t           act_d;
	logic [POS_W-1:0]  pos_d;

	logic              valid_q;
	action_t           action_q;
	logic [POS_W-1:0]  position_q;
	logic              complete_q;

	assign pop = head_valid && (!valid_q || res.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (head_tok.kind)
			KIND_CHAR: begin
				unique case (head_tok.cls)
					CLS_INVALID: state_d = ST_COMPLETE;
					CLS_WORD: begin
						if (state_q == ST_SPACE) state_d = ST_NAME;
						else if (state_q == ST_NAME_GAP) state_d = ST_VALUE;
						else if (state_q == ST_VALUE_GAP) state_d = ST_COMPLETE;
					end
					CLS_SEPARATOR: begin
						if (state_q == ST_NAME) state_d = ST_NAME_GAP;
						else if (state_q == ST_VALUE) state_d = ST_VALUE_GAP;
					end
					default: begin
						if (state_q != ST_SPACE && state_q != ST_COMPLETE) state_d = ST_COMPLETE;
					end
				endcase
			end
			KIND_RESTART: begin
				if (state_q == ST_COMPLETE) state_d = ST_SPACE;
			end
			KIND_OVERFLOW: state_d = ST_COMPLETE;
			default: state_d = state_q;
		endcase
	end

	// action, position and index update
	always_comb begin
		act_d   = ACT_NONE;
		pos_d   = index_q;
		index_d = index_q;
		unique case (head_tok.kind)
			KIND_CHAR: begin
				index_d = next_index(index_q);
				unique case (head_tok.cls)
					CLS_INVALID: act_d = ACT_INVALID;
					CLS_WORD: begin
						if (state_q == ST_SPACE) act_d = ACT_NAME_START;
						else if (state_q == ST_NAME_GAP) act_d = ACT_VALUE_START;
						else if (state_q == ST_VALUE_GAP) act_d = ACT_INVALID;
					end
					CLS_SEPARATOR: begin
						if (state_q == ST_NAME) act_d = ACT_NAME_END;
						else if (state_q == ST_VALUE) act_d = ACT_VALUE_END;
					end
					default: begin
						if (state_q == ST_NAME || state_q == ST_NAME_GAP) act_d = ACT_READ;
						else if (state_q == ST_VALUE || state_q == ST_VALUE_GAP) act_d = ACT_WRITE;
					end
				endcase
			end
			KIND_RESTART: begin
				if (state_q == ST_COMPLETE) begin
					act_d   = ACT_RESTARTED;
					pos_d   = '0;
					index_d = '0;
				end
			end
			KIND_OVERFLOW: begin
				if (state_q != ST_COMPLETE) act_d = ACT_OVERFLOW;
			end
			default: act_d = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SPACE;
			index_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q <= state_d;
				index_q <= index_d;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on each token
	always_ff @(posedge clk) begin
		if (pop) begin
			action_q   <= act_d;
			position_q <= pos_d;
			complete_q <= (state_d == ST_COMPLETE);
		end
	end

	assign res.valid    = valid_q;
	assign res.action   = action_q;
	assign res.position = position_q;
	assign res.complete = complete_q;
endmodule
